// ----- rtl/ppc_pkg.sv -----
// Shared constants, types and helpers of the particle pair collision block.
// No dependencies.
`default_nettype none

package ppc_pkg;

    localparam int NORMAL_BITS = 28;
    localparam int ISQ_STAGES  = 32;   // one root bit per stage, 64-bit radicand
    localparam int DIV_STAGES  = 29;   // one quotient bit per stage, q <= 2^28
    localparam int SIDE_DEPTH  = ISQ_STAGES + DIV_STAGES;

    localparam int RADIUS_W = 31;
    localparam int BOUNCE_W = 17;
    localparam int CFG_W    = 31;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd6554;
    localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 17'd52429;
    localparam logic [17:0]         BOUNCE_ONE   = 18'd65536;

    localparam logic [0:0] REG_RADIUS = 1'b0;
    localparam logic [0:0] REG_BOUNCE = 1'b1;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_IMPULSE  = 2'd1;
    localparam logic [1:0] ST_SEPARATE = 2'd2;
    localparam logic [1:0] ST_COINCIDE = 2'd3;

    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [2:0][32:0] dv;
        logic [2:0][32:0] a;
        logic [2:0]       neg;
        logic             contact;
        logic             coinc;
    } side_t;

    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [2:0][28:0] q;
        logic [2:0]       neg;
        logic             contact;
        logic             coinc;
        logic             closing;
    } post_t;

    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] r;
        if (v > 41'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -41'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ppc_if.sv -----
// Valid/ready channels of the particle pair collision block.
// Input pair of particles and resulting velocities. No dependencies.
`default_nettype none

interface ppc_pair_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_pos_x;
    logic [31:0] first_pos_y;
    logic [31:0] first_pos_z;
    logic [31:0] first_vel_x;
    logic [31:0] first_vel_y;
    logic [31:0] first_vel_z;
    logic [31:0] second_pos_x;
    logic [31:0] second_pos_y;
    logic [31:0] second_pos_z;
    logic [31:0] second_vel_x;
    logic [31:0] second_vel_y;
    logic [31:0] second_vel_z;

    modport source (output valid, first_pos_x, first_pos_y, first_pos_z,
                    first_vel_x, first_vel_y, first_vel_z, second_pos_x,
                    second_pos_y, second_pos_z, second_vel_x, second_vel_y,
                    second_vel_z, input ready);
    modport sink (input valid, first_pos_x, first_pos_y, first_pos_z,
                  first_vel_x, first_vel_y, first_vel_z, second_pos_x,
                  second_pos_y, second_pos_z, second_vel_x, second_vel_y,
                  second_vel_z, output ready);
endinterface

interface ppc_vel_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_new_vel_x;
    logic [31:0] first_new_vel_y;
    logic [31:0] first_new_vel_z;
    logic [31:0] second_new_vel_x;
    logic [31:0] second_new_vel_y;
    logic [31:0] second_new_vel_z;
    logic [1:0]  contact_status;

    modport source (output valid, first_new_vel_x, first_new_vel_y, first_new_vel_z,
                    second_new_vel_x, second_new_vel_y, second_new_vel_z,
                    contact_status, input ready);
    modport sink (input valid, first_new_vel_x, first_new_vel_y, first_new_vel_z,
                  second_new_vel_x, second_new_vel_y, second_new_vel_z,
                  contact_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppc_isqrt.sv -----
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit value.
// One root bit per stage; depends on ppc_pkg.
`default_nettype none

module ppc_isqrt
    import ppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output logic      [31:0] root
);

    logic [63:0] x_reg    [ISQ_STAGES];
    logic [33:0] rem_reg  [ISQ_STAGES];
    logic [31:0] root_reg [ISQ_STAGES];

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
        logic [63:0] x_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [34:0] rem_t;
        logic [34:0] trial;

        if (k == 0) begin : g_first
            assign x_in    = x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits
        assign rem_t = {rem_in[32:0], x_in[63:62]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= {x_in[61:0], 2'b00};
                if (rem_t >= trial)
                begin
                    rem_reg[k]  <= 34'(rem_t - trial);
                    root_reg[k] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_t[33:0];
                    root_reg[k] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[ISQ_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/ppc_div.sv -----
// Pipelined restoring divider for one normal lane: (a << 28) / divisor.
// One quotient bit per stage; depends on ppc_pkg.
`default_nettype none

module ppc_div
    import ppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [32:0] a,
    input  wire logic [31:0] divisor,
    output logic      [28:0] q
);

    logic [31:0] r_reg [DIV_STAGES];
    logic [28:0] q_reg [DIV_STAGES];
    logic [31:0] d_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0] r_in;
        logic [28:0] q_in;
        logic [31:0] d_in;
        logic        b_in;
        logic [32:0] r_t;
        logic        ge;

        // quotient is below 2^29, so the top part of the dividend starts as remainder
        if (k == 0) begin : g_first
            assign r_in = a[32:1];
            assign q_in = '0;
            assign d_in = divisor;
            assign b_in = a[0];
        end else begin : g_next
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign b_in = 1'b0;
        end

        assign r_t = {r_in, b_in};
        assign ge  = r_t >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? 32'(r_t - {1'b0, d_in}) : r_t[31:0];
                q_reg[k] <= {q_in[27:0], ge};
                d_reg[k] <= d_in;
            end
        end
    end

    assign q = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/particle_pair_collision.sv -----
// Top level of the particle pair collision block: contact test, normal,
// impulse and saturation. Depends on ppc_pkg, ppc_if, ppc_isqrt, ppc_div.
//
// Usage:
//   req carries one particle pair per transfer (Q16.16 positions and
//   velocities); rsp returns both new velocities and contact_status.
//   cfg_we/cfg_index/cfg_data write the radius (index 0) and the
//   restitution (index 1); write them only while no pair is in flight.
//   Throughput is one pair per cycle while rsp results are taken. A pair
//   passes through the difference, squares and contact test stages, the
//   bit-per-stage square root, the bit-per-stage normal divider, the dot
//   product, impulse and velocity update stages, and one output register.
//   The whole pipeline advances together: while rsp holds a result that
//   is not taken, req.ready is low and every stage holds its item.
//   Reset empties the pipeline and loads the default radius (6554) and
//   bounce factor (52429). No clearing pass is needed.
`default_nettype none

module particle_pair_collision
    import ppc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    ppc_pair_if.sink              req,
    ppc_vel_if.source             rsp
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [BOUNCE_W-1:0] bounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            bounce_reg <= BOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_BOUNCE: bounce_reg <= cfg_data[BOUNCE_W-1:0];
                default:    ;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;
    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en;

    // ---------------- stage 1: differences, magnitudes, lane range ----------
    logic [31:0] two_r;
    assign two_r = {radius_reg, 1'b0};

    logic [31:0] p1 [3];
    logic [31:0] p2 [3];
    logic [31:0] w1 [3];
    logic [31:0] w2 [3];
    assign p1[0] = req.first_pos_x;
    assign p1[1] = req.first_pos_y;
    assign p1[2] = req.first_pos_z;
    assign p2[0] = req.second_pos_x;
    assign p2[1] = req.second_pos_y;
    assign p2[2] = req.second_pos_z;
    assign w1[0] = req.first_vel_x;
    assign w1[1] = req.first_vel_y;
    assign w1[2] = req.first_vel_z;
    assign w2[0] = req.second_vel_x;
    assign w2[1] = req.second_vel_y;
    assign w2[2] = req.second_vel_z;

    side_t s1_next;
    logic  far_next;

    always_comb
    begin
        logic [32:0] d;
        s1_next  = '0;
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d = {p2[i][31], p2[i]} - {p1[i][31], p1[i]};
            s1_next.v1[i]  = w1[i];
            s1_next.v2[i]  = w2[i];
            s1_next.dv[i]  = {w2[i][31], w2[i]} - {w1[i][31], w1[i]};
            s1_next.neg[i] = d[32];
            s1_next.a[i]   = d[32] ? 33'(33'd0 - d) : d;
            if (s1_next.a[i] >= {1'b0, two_r})
                far_next = 1'b1;
        end
    end

    side_t       s1_reg, s2_reg, s3_reg;
    logic        s1_far_reg, s2_far_reg;
    logic [63:0] sq_reg [3];
    logic [63:0] rr_reg;
    logic [63:0] dsq_reg;
    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg;

    // ---------------- stage 2: squares; stage 3: sum and contact ------------
    logic [65:0] sum_sq;
    assign sum_sq = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    side_t s3_next;

    always_comb
    begin
        s3_next = s2_reg;
        // a sum past 64 bits counts as no contact
        s3_next.contact = !s2_far_reg && (sum_sq[65:64] == 2'b00)
                          && (sum_sq[63:0] < rr_reg);
        s3_next.coinc   = (sum_sq == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s1_far_reg <= far_next;
            s2_reg     <= s1_reg;
            s2_far_reg <= s1_far_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= s1_reg.a[i][31:0] * s1_reg.a[i][31:0];
            rr_reg <= two_r * two_r;

            s3_reg  <= s3_next;
            dsq_reg <= sum_sq[63:0];
        end
    end

    // ---------------- square root and normal divide -------------------------
    logic [31:0] root_len;

    ppc_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .x    (dsq_reg),
        .root (root_len)
    );

    side_t side_reg     [SIDE_DEPTH];
    logic  side_vld_reg [SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s3_reg;
            for (int k = 1; k < SIDE_DEPTH; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    logic [28:0] q [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        ppc_div u_div (
            .clk     (clk),
            .en      (en),
            .a       (side_reg[ISQ_STAGES-1].a[i]),
            .divisor (root_len),
            .q       (q[i])
        );
    end

    side_t tail;
    assign tail = side_reg[SIDE_DEPTH-1];

    // ---------------- dot product, impulse, update --------------------------
    post_t                m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [62:0]   prod_reg [3];
    logic signed [64:0]   s_reg;
    logic        [36:0]   m_reg;
    logic        [54:0]   jp_reg;
    logic        [47:0]   plo_reg [3];
    logic        [47:0]   phi_reg [3];
    logic signed [40:0]   nv1_reg [3];
    logic signed [40:0]   nv2_reg [3];
    logic m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg, m5_vld_reg, m6_vld_reg;

    logic signed [29:0] n [3];
    logic signed [64:0] s_sum;
    logic        [64:0] s_mag;
    logic        [37:0] j_val;
    post_t              m3_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n[i] = tail.neg[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
        s_sum = 65'(prod_reg[0]) + 65'(prod_reg[1]) + 65'(prod_reg[2]);
        s_mag = s_reg[64] ? 65'(-s_reg) : 65'(s_reg);
        j_val = jp_reg[54:17];
        m3_next         = m2_reg;
        m3_next.closing = s_reg[64];
    end

    always_ff @(posedge clk)
    begin
        logic [38:0] imp;
        logic signed [40:0] simp;
        if (en)
        begin
            m1_reg.v1      <= tail.v1;
            m1_reg.v2      <= tail.v2;
            m1_reg.neg     <= tail.neg;
            m1_reg.contact <= tail.contact;
            m1_reg.coinc   <= tail.coinc;
            m1_reg.closing <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                m1_reg.q[i] <= q[i];
                prod_reg[i] <= $signed(tail.dv[i]) * n[i];
            end

            m2_reg <= m1_reg;
            s_reg  <= s_sum;

            m3_reg <= m3_next;
            m_reg  <= s_mag[64:NORMAL_BITS];

            m4_reg <= m3_reg;
            jp_reg <= m_reg * (BOUNCE_ONE + {1'b0, bounce_reg});

            m5_reg <= m4_reg;
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i] <= j_val[18:0]  * m4_reg.q[i];
                phi_reg[i] <= j_val[37:19] * m4_reg.q[i];
            end

            m6_reg <= m5_reg;
            for (int i = 0; i < 3; i++)
            begin
                imp  = 39'(({phi_reg[i], 19'b0} + {19'b0, plo_reg[i]}) >> NORMAL_BITS);
                simp = m5_reg.neg[i] ? -$signed({2'b00, imp}) : $signed({2'b00, imp});
                nv1_reg[i] <= 41'($signed(m5_reg.v1[i])) - simp;
                nv2_reg[i] <= 41'($signed(m5_reg.v2[i])) + simp;
            end
        end
    end

    // ---------------- output register --------------------------------------
    logic [31:0] o1_reg [3];
    logic [31:0] o2_reg [3];
    logic [1:0]  ost_reg;
    logic [1:0]  st_next;

    always_comb
    begin
        if (!m6_reg.contact)
            st_next = ST_NONE;
        else if (m6_reg.coinc)
            st_next = ST_COINCIDE;
        else if (m6_reg.closing)
            st_next = ST_IMPULSE;
        else
            st_next = ST_SEPARATE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ost_reg <= st_next;
            for (int i = 0; i < 3; i++)
            begin
                o1_reg[i] <= (st_next == ST_IMPULSE) ? sat32(nv1_reg[i]) : m6_reg.v1[i];
                o2_reg[i] <= (st_next == ST_IMPULSE) ? sat32(nv2_reg[i]) : m6_reg.v2[i];
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            for (int k = 0; k < SIDE_DEPTH; k++)
                side_vld_reg[k] <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            m4_vld_reg  <= 1'b0;
            m5_vld_reg  <= 1'b0;
            m6_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg      <= req.valid;
            s2_vld_reg      <= s1_vld_reg;
            s3_vld_reg      <= s2_vld_reg;
            side_vld_reg[0] <= s3_vld_reg;
            for (int k = 1; k < SIDE_DEPTH; k++)
                side_vld_reg[k] <= side_vld_reg[k-1];
            m1_vld_reg  <= side_vld_reg[SIDE_DEPTH-1];
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            m4_vld_reg  <= m3_vld_reg;
            m5_vld_reg  <= m4_vld_reg;
            m6_vld_reg  <= m5_vld_reg;
            out_vld_reg <= m6_vld_reg;
        end
    end

    assign rsp.valid            = out_vld_reg;
    assign rsp.first_new_vel_x  = o1_reg[0];
    assign rsp.first_new_vel_y  = o1_reg[1];
    assign rsp.first_new_vel_z  = o1_reg[2];
    assign rsp.second_new_vel_x = o2_reg[0];
    assign rsp.second_new_vel_y = o2_reg[1];
    assign rsp.second_new_vel_z = o2_reg[2];
    assign rsp.contact_status   = ost_reg;

endmodule

`default_nettype wire

// ----- rtl/ppc_checker.sv -----
// Port-level checks of the particle pair collision block, bound to the top.
// Depends on particle_pair_collision.
`default_nettype none

module ppc_port_props (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_status
);

    // pipeline moves as one: input open exactly when output free
    a_ready_tie: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("req.ready does not follow the output stall");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result shown right after reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status))
        else $error("status changed while stalled");

endmodule

bind particle_pair_collision ppc_port_props u_ppc_port_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.contact_status)
);

`default_nettype wire

// ----- verif/ppc_checker.sv -----
// Checker for the particle pair collision block: watches the pair and velocity
// channels, predicts new velocities and status, and counts mismatches.
// Depends on ppc_pkg and ppc_if.
`timescale 1ns / 1ps

module ppc_checker
    import ppc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ppc_pair_if              req,
    ppc_vel_if               rsp,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic [1:0]       status;
    } vel_result_t;

    vel_result_t expected_q[$];
    logic [RADIUS_W-1:0] radius;
    logic [BOUNCE_W-1:0] bounce;

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'h1 << 62;
        while (bit_w > x)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (x >= res + bit_w)
            begin
                x = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic vel_result_t collide(input logic [11:0][31:0] f);
        vel_result_t r;
        longint v1[3], v2[3], d[3], n[3];
        longint unsigned two_r, dsq, a, sq, root_len, q, m, j, imp, mag_s;
        longint s;
        logic contact;
        logic [1:0] st;
        two_r = 64'(radius) * 2;
        dsq = 0;
        contact = 1;
        st = ST_NONE;
        for (int i = 0; i < 3; i++)
        begin
            v1[i] = longint'($signed(f[3+i]));
            v2[i] = longint'($signed(f[9+i]));
            d[i] = longint'($signed(f[6+i])) - longint'($signed(f[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            a = d[i] < 0 ? -d[i] : d[i];
            if (contact && a >= two_r)
                contact = 0;
            if (contact)
            begin
                sq = a * a;
                if (dsq + sq < dsq)
                    contact = 0;
                dsq = dsq + sq;
            end
        end
        if (contact && !(dsq < two_r * two_r))
            contact = 0;
        if (contact && dsq == 0)
            st = ST_COINCIDE;
        else if (contact)
        begin
            root_len = root64(dsq);
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                a = d[i] < 0 ? -d[i] : d[i];
                q = (a << NORMAL_BITS) / root_len;
                n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                s += (v2[i] - v1[i]) * n[i];
            end
            if (s < 0)
            begin
                mag_s = -s;
                m = mag_s >> NORMAL_BITS;
                j = (m * (64'd65536 + 64'(bounce))) >> 17;
                st = ST_IMPULSE;
                for (int i = 0; i < 3; i++)
                begin
                    a = n[i] < 0 ? -n[i] : n[i];
                    imp = (j * a) >> NORMAL_BITS;
                    if (n[i] < 0)
                    begin
                        v1[i] += longint'(imp);
                        v2[i] -= longint'(imp);
                    end
                    else
                    begin
                        v1[i] -= longint'(imp);
                        v2[i] += longint'(imp);
                    end
                end
            end
            else
                st = ST_SEPARATE;
        end
        for (int i = 0; i < 3; i++)
        begin
            r.v1[i] = clamp32(v1[i]);
            r.v2[i] = clamp32(v2[i]);
        end
        r.status = st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius <= RADIUS_RESET;
            bounce <= BOUNCE_RESET;
            fail_count <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            vel_result_t got, exp_r, pred;
            int fails;
            fails = fail_count;
            if (req.valid && req.ready)
            begin
                pred = collide({req.second_vel_z, req.second_vel_y,
                    req.second_vel_x, req.second_pos_z, req.second_pos_y,
                    req.second_pos_x, req.first_vel_z, req.first_vel_y,
                    req.first_vel_x, req.first_pos_z, req.first_pos_y,
                    req.first_pos_x});
                expected_q = {expected_q, pred};
            end
            if (rsp.valid && rsp.ready)
            begin
                got.v1 = {rsp.first_new_vel_z, rsp.first_new_vel_y, rsp.first_new_vel_x};
                got.v2 = {rsp.second_new_vel_z, rsp.second_new_vel_y,
                          rsp.second_new_vel_x};
                got.status = rsp.contact_status;
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, got);
                    fails++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got.v1[i] != exp_r.v1[i])
                        begin
                            $display("%0t first vel[%0d] exp %h got %h", $time, i,
                                     exp_r.v1[i], got.v1[i]);
                            fails++;
                        end
                        if (got.v2[i] != exp_r.v2[i])
                        begin
                            $display("%0t second vel[%0d] exp %h got %h", $time, i,
                                     exp_r.v2[i], got.v2[i]);
                            fails++;
                        end
                    end
                    if (got.status != exp_r.status)
                    begin
                        $display("%0t status exp %0d got %0d", $time,
                                 exp_r.status, got.status);
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            pending <= expected_q.size();
            if (cfg_we)
            begin
                if (cfg_index == REG_RADIUS)
                    radius <= cfg_data[RADIUS_W-1:0];
                else if (cfg_index == REG_BOUNCE)
                    bounce <= cfg_data[BOUNCE_W-1:0];
            end
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Testbench top for particle_pair_collision: drives pairs and register writes,
// stalls the result side, and reports the verdict. Depends on ppc_checker.
`timescale 1ns / 1ps

module testbench;
    import ppc_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [0:0] cfg_index = REG_RADIUS;
    logic [CFG_W-1:0] cfg_data = 0;
    int fail_count, pending;
    int cycles = 0;
    logic [RADIUS_W-1:0] cur_radius = RADIUS_RESET;

    ppc_pair_if req();
    ppc_vel_if rsp();

    particle_pair_collision DUT (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
                                 .req(req.sink), .rsp(rsp.source));
    ppc_checker u_checker (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .req, .rsp,
                           .fail_count, .pending);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // result-side stalls
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(negedge clk);
            rsp.ready = 1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
            rsp.ready = 0;
            repeat (gap_len()) @(negedge clk);
        end
    end

    task automatic send_pair(input logic [11:0][31:0] f);
        {req.second_vel_z, req.second_vel_y, req.second_vel_x, req.second_pos_z,
         req.second_pos_y, req.second_pos_x, req.first_vel_z, req.first_vel_y,
         req.first_vel_x, req.first_pos_z, req.first_pos_y, req.first_pos_x} = f;
        req.valid = 1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        req.valid = 0;
        repeat (gap_len()) @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_index = idx;
        cfg_data = val;
        cfg_we = 1;
        if (idx == REG_RADIUS)
            cur_radius = val[RADIUS_W-1:0];
        @(negedge clk);
        cfg_we = 0;
    endtask

    function automatic logic [31:0] rand32();
        return $urandom;
    endfunction

    // near pair: second particle within one radius of the first on each axis
    function automatic logic [11:0][31:0] near_pair(input int vel_span);
        logic [11:0][31:0] f;
        int span;
        span = (cur_radius > 32'd600000000) ? 600000000 : int'(cur_radius);
        for (int i = 0; i < 3; i++)
        begin
            f[i] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
            f[6+i] = f[i] + ($urandom_range(0, 2*span) - span);
            if (vel_span == 0)
            begin
                f[3+i] = rand32();
                f[9+i] = rand32();
            end
            else
            begin
                f[3+i] = $urandom_range(0, 2*vel_span) - vel_span;
                f[9+i] = $urandom_range(0, 2*vel_span) - vel_span;
            end
        end
        return f;
    endfunction

    function automatic logic [11:0][31:0] fill(input logic [31:0] p1, p2, v1, v2);
        logic [11:0][31:0] f;
        for (int i = 0; i < 3; i++)
        begin
            f[i] = p1;
            f[6+i] = p2;
            f[3+i] = v1;
            f[9+i] = v2;
        end
        return f;
    endfunction

    initial
    begin
        logic [11:0][31:0] f;
        req.valid = 0;
        {req.first_pos_x, req.first_pos_y, req.first_pos_z, req.first_vel_x,
         req.first_vel_y, req.first_vel_z, req.second_pos_x, req.second_pos_y,
         req.second_pos_z, req.second_vel_x, req.second_vel_y, req.second_vel_z} = '0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: reset registers
        send_pair(fill(0, 0, 32'h0001_0000, 0));               // coincident
        send_pair(fill(0, 1000, 32'h0001_0000, 0));            // closing
        send_pair(fill(0, 1000, 0, 32'h0001_0000));            // separating
        send_pair(fill(0, 1000, 0, 0));                        // resting
        send_pair(fill(0, 20000, 32'h0001_0000, 0));           // far apart
        send_pair(fill(32'h8000_0000, 32'h7FFF_FFFF, 1, 0));   // huge distance
        send_pair(fill(0, 100, 32'h7FFF_FFFF, 32'h8000_0000)); // extreme velocities
        send_pair(fill(0, 32'hFFFF_FF00, 32'h8000_0000, 32'h7FFF_FFFF));
        f = fill(0, 0, 32'h0001_0000, 32'hFFFF_0000);
        f[6] = 13108;                                          // exactly 2r: no contact
        send_pair(f);
        f[6] = 13107;
        send_pair(f);

        write_reg(REG_RADIUS, 31'h7FFF_FFFF);
        write_reg(REG_BOUNCE, CFG_W'(17'd65536));
        send_pair(fill(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_pair(fill(32'hC000_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'hC000_0000));
        send_pair(fill(0, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
        write_reg(REG_BOUNCE, CFG_W'(17'h1FFFF));              // bounce above one
        send_pair(fill(0, 5, 32'h7FFF_FFFF, 32'h8000_0000));
        write_reg(REG_BOUNCE, '0);
        send_pair(fill(0, 5, 32'h0100_0000, 32'hFF00_0000));
        write_reg(REG_RADIUS, '0);                             // never in contact
        send_pair(fill(0, 0, 1, 2));
        write_reg(REG_RADIUS, CFG_W'(1));
        send_pair(fill(0, 1, 32'h0001_0000, 0));
        send_pair(fill(0, 0, 32'h0001_0000, 0));

        // random phases over several settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: write_reg(REG_RADIUS, CFG_W'($urandom_range(1, 65536)));
                1: write_reg(REG_RADIUS, CFG_W'($urandom_range(1, 32'h7FFF_FFFF)));
                2: write_reg(REG_RADIUS, CFG_W'($urandom_range(1, 64)));
                default: write_reg(REG_RADIUS, 31'h7FFF_FFFF);
            endcase
            write_reg(REG_BOUNCE, CFG_W'($urandom_range(0, 17'h1FFFF)));
            for (int k = 0; k < 62; k++)
            begin
                case ($urandom_range(0, 9))
                    0: f = {rand32(), rand32(), rand32(), rand32(), rand32(), rand32(),
                            rand32(), rand32(), rand32(), rand32(), rand32(), rand32()};
                    1: f = near_pair(0);
                    2:
                    begin
                        f = near_pair(1 << 20);
                        for (int i = 0; i < 3; i++)
                            f[6+i] = f[i];
                    end
                    default: f = near_pair(1 << $urandom_range(4, 30));
                endcase
                send_pair(f);
            end
            if (phase == 3)
                drain();                                       // hold off until all results in
        end

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ppc_pkg.sv
rtl/ppc_if.sv
rtl/ppc_isqrt.sv
rtl/ppc_div.sv
rtl/particle_pair_collision.sv
rtl/ppc_checker.sv
verif/ppc_checker.sv
verif/testbench.sv
